// ----- rtl/cldrt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cldrt_pkg: shared definitions of the dirty range tracker
// Line geometry, request codes, register indexes and the command and status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package cldrt_pkg;

  localparam int MAX_LINES  = 64;
  localparam int LINE_SHIFT = 6;
  localparam int ADDR_W     = 64;
  localparam int BASE_W     = ADDR_W - LINE_SHIFT;
  localparam int LINE_IDX_W = $clog2(MAX_LINES);
  localparam int LINE_CNT_W = $clog2(MAX_LINES + 1);
  localparam int BYTES_W    = LINE_CNT_W + LINE_SHIFT;
  localparam int CFG_IDX_W  = 1;
  localparam int GRP_W      = 8;
  localparam int GRP_N      = MAX_LINES / GRP_W;
  localparam int GRP_CNT_W  = $clog2(GRP_W + 1);

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_BASE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LINES = 1'd1;

  typedef enum logic [1:0] {
    ACT_MARK      = 2'd0,
    ACT_CLEAR     = 2'd1,
    ACT_CLEAR_ALL = 2'd2,
    ACT_REPORT    = 2'd3
  } action_t;

  typedef struct packed {
    logic load;
    logic check;
    logic apply;
    logic scan_adv;
    logic emit;
    logic emit_run;
    logic emit_last;
  } ctrl_cmd_t;

  typedef struct packed {
    action_t act;
    logic    cur_set;
    logic    cur_end;
    logic    in_run;
    logic    rest_any;
  } dp_stat_t;

endpackage

// ----- rtl/cldrt_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cldrt_if: request and result channels
// Valid/ready channels carrying one request or one result per transfer.
// ----------------------------------------------------------------------------
interface cldrt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [63:0] address;
  logic [63:0] size;

  modport source (output valid, output action, output address, output size, input ready);
  modport sink   (input valid, input action, input address, input size, output ready);
endinterface

interface cldrt_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [63:0] range_address;
  logic [12:0] range_bytes;
  logic [12:0] dirty_bytes;
  logic        last;

  modport source (output valid, output accepted, output range_address, output range_bytes,
                  output dirty_bytes, output last, input ready);
  modport sink   (input valid, input accepted, input range_address, input range_bytes,
                  input dirty_bytes, input last, output ready);
endinterface

// ----- rtl/cldrt_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cldrt_dp: tracker datapath
// Window registers, dirty map, range check and mask, line walk for reports,
// two-stage dirty line count and the result register.
// ----------------------------------------------------------------------------
module cldrt_dp import cldrt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ctrl_cmd_t              cmd,
  output dp_stat_t               stat,
  input  logic [1:0]             in_action,
  input  logic [ADDR_W-1:0]      in_address,
  input  logic [ADDR_W-1:0]      in_size,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [BASE_W-1:0]      cfg_wdata,
  output logic                   out_accepted,
  output logic [ADDR_W-1:0]      out_range_address,
  output logic [BYTES_W-1:0]     out_range_bytes,
  output logic [BYTES_W-1:0]     out_dirty_bytes,
  output logic                   out_last
);

  function automatic logic [GRP_CNT_W-1:0] popcnt_grp(input logic [GRP_W-1:0] v);
    logic [GRP_CNT_W-1:0] c;
    c = '0;
    for (int k = 0; k < GRP_W; k++) c = c + GRP_CNT_W'(v[k]);
    return c;
  endfunction

  logic [BASE_W-1:0]     base_line_r;
  logic [LINE_CNT_W-1:0] win_lines_r;
  logic [MAX_LINES-1:0]  map_r;
  action_t               act_r;
  logic [ADDR_W-1:0]     addr_r;
  logic [ADDR_W-1:0]     size_r;
  logic [ADDR_W:0]       off_r;
  logic                  ovf_r;
  logic                  acc_r;
  logic [LINE_CNT_W-1:0] cursor_r;
  logic [LINE_IDX_W-1:0] run_start_r;
  logic                  in_run_r;
  logic [GRP_CNT_W-1:0]  part_r [GRP_N];
  logic [LINE_CNT_W-1:0] cnt_r;

  logic [LINE_CNT_W-1:0] eff_lines;
  logic [ADDR_W-1:0]     base_addr;
  logic [ADDR_W:0]       diff_w;
  logic [ADDR_W:0]       sum_w;
  logic [BYTES_W:0]      sum_s;
  logic [BYTES_W:0]      end_s;
  logic                  in_win;
  logic                  aligned;
  logic                  req_ok;
  logic [LINE_IDX_W-1:0] lo_line;
  logic [LINE_IDX_W-1:0] hi_line;
  logic [MAX_LINES-1:0]  line_mask;
  logic [MAX_LINES-1:0]  rest_bits;
  logic [LINE_CNT_W-1:0] cnt_sum;
  logic [LINE_CNT_W-1:0] run_len;

  assign eff_lines = (win_lines_r > LINE_CNT_W'(MAX_LINES)) ? LINE_CNT_W'(MAX_LINES)
                                                            : win_lines_r;
  assign base_addr = {base_line_r, LINE_SHIFT'(0)};

  // range check, split over the check and apply states
  assign diff_w = {1'b0, addr_r} - {1'b0, base_addr};
  assign sum_w  = {1'b0, addr_r} + {1'b0, size_r};

  assign sum_s  = {1'b0, off_r[BYTES_W-1:0]} + {1'b0, size_r[BYTES_W-1:0]};
  assign end_s  = sum_s - (BYTES_W+1)'(1);
  assign in_win = (size_r != '0) && !off_r[ADDR_W] && !ovf_r
               && (off_r[ADDR_W-1:BYTES_W] == '0) && (size_r[ADDR_W-1:BYTES_W] == '0)
               && (sum_s <= {1'b0, eff_lines, LINE_SHIFT'(0)});
  assign aligned = (addr_r[LINE_SHIFT-1:0] == '0) && (size_r[LINE_SHIFT-1:0] == '0);
  assign lo_line = off_r[LINE_SHIFT+LINE_IDX_W-1:LINE_SHIFT];
  assign hi_line = end_s[LINE_SHIFT+LINE_IDX_W-1:LINE_SHIFT];

  always_comb begin
    for (int i = 0; i < MAX_LINES; i++) begin
      line_mask[i] = (LINE_IDX_W'(i) >= lo_line) && (LINE_IDX_W'(i) <= hi_line);
      rest_bits[i] = map_r[i] && (LINE_CNT_W'(i) >= cursor_r);
    end
  end

  always_comb begin
    case (act_r)
      ACT_MARK:  req_ok = in_win;
      ACT_CLEAR: req_ok = in_win && aligned;
      default:   req_ok = 1'b1;
    endcase
  end

  // window registers and dirty map
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_line_r <= '0;
      win_lines_r <= LINE_CNT_W'(MAX_LINES);
      map_r       <= '0;
    end else if (cfg_we) begin
      map_r <= '0;
      case (cfg_index)
        REG_WINDOW_BASE:  base_line_r <= cfg_wdata;
        REG_WINDOW_LINES: win_lines_r <= cfg_wdata[LINE_CNT_W-1:0];
        default: ;
      endcase
    end else if (cmd.apply) begin
      case (act_r)
        ACT_MARK:      if (req_ok) map_r <= map_r | line_mask;
        ACT_CLEAR:     if (req_ok) map_r <= map_r & ~line_mask;
        ACT_CLEAR_ALL: map_r <= '0;
        default: ;
      endcase
    end
  end

  // request capture and check
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= action_t'(in_action);
      addr_r <= in_address;
      size_r <= in_size;
    end
    if (cmd.check) begin
      off_r <= diff_w;
      ovf_r <= sum_w[ADDR_W];
    end
    if (cmd.apply) acc_r <= req_ok;
  end

  // line walk for reports
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
      in_run_r <= 1'b0;
    end else if (cmd.load) begin
      cursor_r <= '0;
      in_run_r <= 1'b0;
    end else if (cmd.emit_run) begin
      cursor_r <= cursor_r + LINE_CNT_W'(1);
      in_run_r <= 1'b0;
    end else if (cmd.scan_adv) begin
      cursor_r <= cursor_r + LINE_CNT_W'(1);
      if (stat.cur_set && !in_run_r) begin
        in_run_r    <= 1'b1;
        run_start_r <= cursor_r[LINE_IDX_W-1:0];
      end
    end
  end

  // dirty line count, two register stages behind the map
  always_comb begin
    cnt_sum = '0;
    for (int g = 0; g < GRP_N; g++) cnt_sum = cnt_sum + LINE_CNT_W'(part_r[g]);
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < GRP_N; g++) part_r[g] <= popcnt_grp(map_r[g*GRP_W +: GRP_W]);
    cnt_r <= cnt_sum;
  end

  // result register
  assign run_len = cursor_r - {1'b0, run_start_r};

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_accepted    <= cmd.emit_run ? 1'b1 : acc_r;
      out_range_address <= cmd.emit_run
                         ? base_addr + ADDR_W'({run_start_r, LINE_SHIFT'(0)}) : '0;
      out_range_bytes <= cmd.emit_run ? {run_len, LINE_SHIFT'(0)} : '0;
      out_dirty_bytes <= {cnt_r, LINE_SHIFT'(0)};
      out_last        <= cmd.emit_last;
    end
  end

  assign stat.act      = act_r;
  assign stat.cur_end  = (cursor_r >= eff_lines);
  assign stat.cur_set  = map_r[cursor_r[LINE_IDX_W-1:0]];
  assign stat.in_run   = in_run_r;
  assign stat.rest_any = |rest_bits;

endmodule

// ----- rtl/cldrt_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cldrt_ctrl: tracker controller
// Sequences check, apply, count settle and result or run emission for one
// request at a time; owns the channel handshakes.
// ----------------------------------------------------------------------------
module cldrt_ctrl import cldrt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output ctrl_cmd_t cmd,
  input  dp_stat_t  stat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_APPLY,
    S_CNT1,
    S_CNT2,
    S_EMIT,
    S_SCAN
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;
  logic   run_done;

  assign slot_free = !out_valid_r || out_ready;
  assign run_done  = stat.in_run && (stat.cur_end || !stat.cur_set);

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    in_ready_nxt  = in_ready_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.load     = 1'b1;
          in_ready_nxt = 1'b0;
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = S_CNT1;
      end
      S_CNT1: state_nxt = S_CNT2;
      S_CNT2: state_nxt = (stat.act == ACT_REPORT) ? S_SCAN : S_EMIT;
      S_EMIT: begin
        if (slot_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          out_valid_nxt = 1'b1;
          in_ready_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_SCAN: begin
        if (run_done) begin
          if (slot_free) begin
            cmd.emit      = 1'b1;
            cmd.emit_run  = 1'b1;
            cmd.emit_last = !stat.rest_any;
            out_valid_nxt = 1'b1;
            if (!stat.rest_any) begin
              in_ready_nxt = 1'b1;
              state_nxt    = S_IDLE;
            end
          end
        end else if (stat.cur_end) begin
          // no dirty line in the window
          if (slot_free) begin
            cmd.emit      = 1'b1;
            cmd.emit_last = 1'b1;
            out_valid_nxt = 1'b1;
            in_ready_nxt  = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          cmd.scan_adv = 1'b1;
        end
      end
      default: begin
        in_ready_nxt = 1'b1;
        state_nxt    = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_ready_r  <= in_ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

endmodule

// ----- rtl/cache_line_dirty_range_tracker_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cache_line_dirty_range_tracker_top: dirty line tracker for a 64-line window
//
//   port     dir  handshake    contents
//   in_req   in   valid/ready  action, address, size
//   out_rsp  out  valid/ready  accepted, range_address, range_bytes,
//                              dirty_bytes, last
//   cfg_*    in   cfg_we       cfg_index, cfg_wdata
//
// mark, clear and clear-all step from request transfer to the earliest result
// transfer through capture, 64-bit range check, mask apply, the dirty line
// count settling in S_CNT1 and S_CNT2, then the result register.
// report then walks the window, ending after the last dirty run (at the window end
// when no line is dirty); the walk looks at one line a cycle while out_rsp is free,
// and a run goes out in the cycle that finds its end unless out_rsp stalls it.
// one request at a time; a waiting result sits in the output register while
// the next request is taken, and further results stall on out_rsp.ready.
// rst_n is synchronous: map clean, window base 0, window length 64 lines.
// a configuration write clears the whole map.
// ----------------------------------------------------------------------------
module cache_line_dirty_range_tracker_top import cldrt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  cldrt_in_if.sink             in_req,
  cldrt_out_if.source          out_rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BASE_W-1:0]    cfg_wdata
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  cldrt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  cldrt_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_action         (in_req.action),
    .in_address        (in_req.address),
    .in_size           (in_req.size),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_accepted      (out_rsp.accepted),
    .out_range_address (out_rsp.range_address),
    .out_range_bytes   (out_rsp.range_bytes),
    .out_dirty_bytes   (out_rsp.dirty_bytes),
    .out_last          (out_rsp.last)
  );

  // one request in flight
  assert property (@(posedge clk) disable iff (!rst_n)
    in_req.valid && in_req.ready |=> !in_req.ready)
    else $error("request taken while another is in flight");

  // a rejected request yields a single empty result
  assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid && !out_rsp.accepted |->
      out_rsp.last && (out_rsp.range_bytes == '0) && (out_rsp.range_address == '0))
    else $error("rejected request with range or continuation");

  // a reported run never exceeds the dirty total
  assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid |-> out_rsp.range_bytes <= out_rsp.dirty_bytes)
    else $error("run longer than dirty byte count");

  // the dirty byte count stays whole lines inside the 64-line limit
  assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid |-> (out_rsp.dirty_bytes[LINE_SHIFT-1:0] == '0)
      && (out_rsp.dirty_bytes <= BYTES_W'(MAX_LINES << LINE_SHIFT)))
    else $error("dirty byte count out of range");

endmodule
